[hw/rtl/led_keyframe_pattern_builder_defines.svh]
// Assertion macros shared by the checker file.
`ifndef LED_KEYFRAME_PATTERN_BUILDER_DEFINES_SVH
`define LED_KEYFRAME_PATTERN_BUILDER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst is high.
`define LKPB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, sampled on clk, quiet while rst is high.
`define LKPB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

[hw/rtl/lkpb_pkg.sv]
package lkpb_pkg;

  localparam int PATTERN_SAMPLES_DEF = 32;

  localparam int FUNC_W   = 3;
  localparam int SAMPLE_W = 6;
  localparam int CHAN_W   = 8;
  localparam int NUM_CHAN = 3;
  localparam int COLOUR_W = CHAN_W * NUM_CHAN;
  localparam int INDEX_W  = 5;
  localparam int TIME_W   = 12;
  localparam int CFG_IDX_W = 4;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_PAUSE = CFG_IDX_W'(1);

  typedef enum logic [FUNC_W-1:0] {
    OP_ADD  = 3'd0,
    OP_DEL  = 3'd1,
    OP_CLR  = 3'd2,
    OP_PLAY = 3'd3,
    OP_STOP = 3'd4
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [SAMPLE_W-1:0] slot;
    logic [COLOUR_W-1:0] colour;
    logic                hold;
  } cmd_t;

  // Divider request: per-channel magnitude of (next - current) and its sign.
  typedef struct packed {
    logic                              start;
    logic [NUM_CHAN-1:0]               neg;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]   mag;
  } div_req_t;

  typedef struct packed {
    logic                              done;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]   quot;
  } div_rsp_t;

  function automatic logic [CHAN_W-1:0] sat_byte(input logic [TIME_W-1:0] v);
    sat_byte = (|v[TIME_W-1:CHAN_W]) ? {CHAN_W{1'b1}} : v[CHAN_W-1:0];
  endfunction

endpackage

[hw/rtl/lkpb_if.sv]
interface lkpb_cmd_if import lkpb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [SAMPLE_W-1:0] sample;
  logic [CHAN_W-1:0]   red;
  logic [CHAN_W-1:0]   green;
  logic [CHAN_W-1:0]   blue;
  logic                hold;

  modport source (output valid, func, sample, red, green, blue, hold, input ready);
  modport sink   (input valid, func, sample, red, green, blue, hold, output ready);
endinterface

interface lkpb_smp_if import lkpb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] sample_index;
  logic [CHAN_W-1:0]  out_red;
  logic [CHAN_W-1:0]  out_green;
  logic [CHAN_W-1:0]  out_blue;
  logic [CHAN_W-1:0]  step_delay;
  logic [CHAN_W-1:0]  loop_pause;
  logic               last;

  modport source (output valid, sample_index, out_red, out_green, out_blue,
                  step_delay, loop_pause, last, input ready);
  modport sink   (input valid, sample_index, out_red, out_green, out_blue,
                  step_delay, loop_pause, last, output ready);
endinterface

interface lkpb_cfg_if import lkpb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TIME_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/lkpb_ram.sv]
module lkpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/lkpb_front.sv]
module lkpb_front import lkpb_pkg::*; #(
  parameter int PATTERN_SAMPLES = PATTERN_SAMPLES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lkpb_cmd_if.sink   cmd,
  input  logic       full,
  output logic       push,
  output cmd_t       word
);

  logic   playing;
  logic   accept;
  logic   in_range;
  op_t    op;

  assign cmd.ready = !full;
  assign accept    = cmd.valid && cmd.ready;
  assign op        = op_t'(cmd.func);
  assign in_range  = int'(cmd.sample) < PATTERN_SAMPLES;

  assign word.op     = op;
  assign word.slot   = cmd.sample;
  assign word.colour = {cmd.red, cmd.green, cmd.blue};
  assign word.hold   = cmd.hold;

  // Drop beats that change nothing; queue the rest in order.
  always_comb begin
    push = 1'b0;
    case (op)
      OP_ADD, OP_DEL:   push = accept && in_range;
      OP_CLR, OP_PLAY:  push = accept;
      OP_STOP:          push = accept && playing;
      default:          push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      playing <= 1'b0;
    end else if (accept) begin
      if (op == OP_PLAY) begin
        playing <= 1'b1;
      end else if (op == OP_STOP) begin
        playing <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/lkpb_cmd_fifo.sv]
module lkpb_cmd_fifo import lkpb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_word,
  output logic full,
  input  logic pop,
  output logic avail,
  output cmd_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(QUEUE_DEPTH);
  assign avail = count != '0;
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/lkpb_div.sv]
module lkpb_div import lkpb_pkg::*; #(
  parameter int DVS_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  input  logic [DVS_W-1:0] dvs,
  output div_rsp_t         rsp
);

  localparam int CNT_W = $clog2(CHAN_W + 1);

  logic                            busy;
  logic                            done;
  logic [CNT_W-1:0]                cnt;
  logic [DVS_W-1:0]                dvs_q;
  logic [NUM_CHAN-1:0]             neg_q;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] q;
  logic [NUM_CHAN-1:0][DVS_W-1:0]  rem;
  logic [NUM_CHAN-1:0][DVS_W:0]    trial;
  logic [NUM_CHAN-1:0]             fits;

  // One restoring step per cycle, all three channels share the divisor.
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      trial[c] = {rem[c], q[c][CHAN_W-1]};
      fits[c]  = trial[c] >= {1'b0, dvs_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(CHAN_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvs_q <= dvs;
      neg_q <= req.neg;
      for (int c = 0; c < NUM_CHAN; c++) begin
        q[c]   <= req.mag[c];
        rem[c] <= '0;
      end
    end else if (busy) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        q[c]   <= {q[c][CHAN_W-2:0], fits[c]};
        rem[c] <= fits[c] ? DVS_W'(trial[c] - {1'b0, dvs_q}) : trial[c][DVS_W-1:0];
      end
    end
  end

  // Truncate toward zero: negate the magnitude quotient.
  always_comb begin
    rsp.done = done;
    for (int c = 0; c < NUM_CHAN; c++) begin
      rsp.quot[c] = neg_q[c] ? CHAN_W'(-q[c]) : q[c];
    end
  end

endmodule

[hw/rtl/lkpb_back.sv]
module lkpb_back import lkpb_pkg::*; #(
  parameter int PATTERN_SAMPLES = PATTERN_SAMPLES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              avail,
  input  cmd_t              head,
  output logic              pop,
  input  logic [TIME_W-1:0] step_time,
  input  logic [TIME_W-1:0] loop_pause_time,
  lkpb_smp_if.source        smp
);

  localparam int SLOT_W = (PATTERN_SAMPLES > 1) ? $clog2(PATTERN_SAMPLES) : 1;
  localparam int CNT_W  = SLOT_W + 1;
  localparam logic [CNT_W-1:0] NUM      = CNT_W'(PATTERN_SAMPLES);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(PATTERN_SAMPLES - 1);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SCAN = 8'b0000_0010,
    ST_GOT  = 8'b0000_0100,
    ST_LEAD = 8'b0000_1000,
    ST_DIV  = 8'b0001_0000,
    ST_SEG  = 8'b0010_0000,
    ST_TAIL = 8'b0100_0000,
    ST_ZERO = 8'b1000_0000
  } state_t;

  state_t                          state;
  logic [PATTERN_SAMPLES-1:0]      slot_valid;
  logic [CNT_W-1:0]                p;
  logic [CNT_W-1:0]                s;
  logic [CNT_W-1:0]                i;
  logic                            have_key;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] acc;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] step;
  logic [COLOUR_W-1:0]             b_col;

  logic [CNT_W-1:0]                slot_ext;
  logic [COLOUR_W:0]               rd_word;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] rd_col;
  logic                            rd_hold;
  logic                            emit_ok;
  logic                            emit;
  logic [COLOUR_W-1:0]             emit_col;
  logic                            emit_dly;
  logic                            ram_we;
  logic [SLOT_W-1:0]               ram_waddr;
  logic [COLOUR_W:0]               ram_wdata;
  div_req_t                        dreq;
  div_rsp_t                        drsp;
  logic [SLOT_W-1:0]               span;

  assign slot_ext = CNT_W'(head.slot);
  assign pop      = (state == ST_IDLE) && avail;
  // Reset writes slot 0 black; afterwards only add writes the table.
  assign ram_we    = rst || (pop && (head.op == OP_ADD));
  assign ram_waddr = rst ? '0 : slot_ext[SLOT_W-1:0];
  assign ram_wdata = rst ? '0 : {head.hold, head.colour};
  assign rd_col   = rd_word[COLOUR_W-1:0];
  assign rd_hold  = rd_word[COLOUR_W];
  assign span     = SLOT_W'(p - s);

  lkpb_ram #(
    .WIDTH (COLOUR_W + 1),
    .DEPTH (PATTERN_SAMPLES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (p[SLOT_W-1:0]),
    .rdata (rd_word)
  );

  always_comb begin
    dreq.start = (state == ST_GOT) && have_key && !rd_hold;
    for (int c = 0; c < NUM_CHAN; c++) begin
      dreq.neg[c] = rd_col[c] < acc[c];
      dreq.mag[c] = dreq.neg[c] ? acc[c] - rd_col[c] : rd_col[c] - acc[c];
    end
  end

  lkpb_div #(
    .DVS_W (SLOT_W)
  ) u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .dvs (span),
    .rsp (drsp)
  );

  // Load the output register whenever it is empty or being drained.
  assign emit_ok  = !smp.valid || smp.ready;
  assign emit     = emit_ok && (((state == ST_LEAD) && (i != s)) || (state == ST_SEG) ||
                                (state == ST_TAIL) || (state == ST_ZERO));
  assign emit_col = ((state == ST_SEG) || (state == ST_TAIL)) ? acc : '0;
  assign emit_dly = state != ST_ZERO;

  always_ff @(posedge clk) begin
    if (emit) begin
      smp.sample_index <= INDEX_W'(i);
      {smp.out_red, smp.out_green, smp.out_blue} <= emit_col;
      smp.step_delay   <= emit_dly ? sat_byte(step_time) : '0;
      smp.loop_pause   <= emit_dly ? sat_byte(loop_pause_time) : '0;
      smp.last         <= i == LAST_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_valid <= PATTERN_SAMPLES'(1);
      smp.valid  <= 1'b0;
      have_key   <= 1'b0;
    end else begin
      if (emit) begin
        smp.valid <= 1'b1;
        i         <= i + 1'b1;
      end else if (smp.ready) begin
        smp.valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (avail) begin
            case (head.op)
              OP_ADD:  slot_valid[slot_ext[SLOT_W-1:0]] <= 1'b1;
              OP_DEL:  slot_valid[slot_ext[SLOT_W-1:0]] <= 1'b0;
              OP_CLR:  slot_valid <= '0;
              OP_PLAY: begin
                p        <= '0;
                i        <= '0;
                acc      <= '0;
                have_key <= 1'b0;
                state    <= ST_SCAN;
              end
              OP_STOP: begin
                i     <= '0;
                state <= ST_ZERO;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (p == NUM) begin
            state <= ST_TAIL;
          end else if (slot_valid[p[SLOT_W-1:0]]) begin
            state <= ST_GOT;
          end else begin
            p <= p + 1'b1;
          end
        end
        ST_GOT: begin
          b_col <= rd_col;
          if (!have_key) begin
            have_key <= 1'b1;
            s        <= p;
            acc      <= rd_col;
            state    <= ST_LEAD;
          end else if (rd_hold) begin
            step  <= '0;
            state <= ST_SEG;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_LEAD: begin
          // Zeros up to the first keyframe.
          if (i == s) begin
            p     <= s + 1'b1;
            state <= ST_SCAN;
          end
        end
        ST_DIV: begin
          if (drsp.done) begin
            step  <= drsp.quot;
            state <= ST_SEG;
          end
        end
        ST_SEG: begin
          if (emit) begin
            if (i + 1'b1 == p) begin
              acc   <= b_col;
              s     <= p;
              p     <= p + 1'b1;
              state <= ST_SCAN;
            end else begin
              for (int c = 0; c < NUM_CHAN; c++) begin
                acc[c] <= acc[c] + step[c];
              end
            end
          end
        end
        ST_TAIL, ST_ZERO: begin
          if (emit && (i == LAST_IDX)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/led_keyframe_pattern_builder.sv]
// Keyframe pattern builder for an RGB LED. Command beats on cmd add or
// overwrite a keyframe slot (red, green, blue and a hold flag), delete one,
// clear the table, play or stop; slots at or beyond PATTERN_SAMPLES are
// ignored, and after reset only slot 0 holds a keyframe (black). Play streams
// PATTERN_SAMPLES beats on smp, sample 0 first: colours ramp linearly between
// keyframes with the per-sample step truncated toward zero, stay flat into a
// keyframe whose hold flag is set, hold the last keyframe to the end and are
// black before the first. Each play beat carries step_time and loop_pause_time
// from the cfg port (index 0 and 1), saturated to 255. Stop streams the same
// number of all-zero beats, but only after a play; last marks the final beat
// of every run. Write cfg only while no run is in flight. Reset writes slot 0
// black into the table, so hold rst for at least one clock.
// Rate: add, delete and clear are applied by the engine as it pops them; a play
// run is paced by a slot scan of one slot a cycle, a registered table read per
// keyframe and a shift-subtract divider per ramp, with one sample leaving per
// cycle when smp does not stall. A two-entry command queue lets cmd keep
// accepting beats while a run is being streamed.
module led_keyframe_pattern_builder import lkpb_pkg::*; #(
  parameter int PATTERN_SAMPLES = PATTERN_SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  lkpb_cmd_if.sink    cmd,
  lkpb_smp_if.source  smp,
  lkpb_cfg_if.sink    cfg
);

  logic [TIME_W-1:0] step_time;
  logic [TIME_W-1:0] loop_pause_time;

  logic q_full;
  logic q_push;
  cmd_t q_in;
  logic q_pop;
  logic q_avail;
  cmd_t q_head;

  // Register file: always ready, unknown indexes drop silently.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time       <= '0;
      loop_pause_time <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_STEP_TIME:  step_time       <= cfg.data;
        REG_LOOP_PAUSE: loop_pause_time <= cfg.data;
        default: ;
      endcase
    end
  end

  // Front: accept and classify commands, track whether a play is live.
  lkpb_front #(
    .PATTERN_SAMPLES (PATTERN_SAMPLES)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .full (q_full),
    .push (q_push),
    .word (q_in)
  );

  // Short queue parting the front from the engine.
  lkpb_cmd_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .head      (q_head)
  );

  // Back: keyframe table, ramp sequencer and output register.
  lkpb_back #(
    .PATTERN_SAMPLES (PATTERN_SAMPLES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .avail           (q_avail),
    .head            (q_head),
    .pop             (q_pop),
    .step_time       (step_time),
    .loop_pause_time (loop_pause_time),
    .smp             (smp)
  );

endmodule

[hw/rtl/lkpb_checker.sv]
`include "led_keyframe_pattern_builder_defines.svh"

module lkpb_checker import lkpb_pkg::*; #(
  parameter int PATTERN_SAMPLES = PATTERN_SAMPLES_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               smp_valid,
  input logic               smp_ready,
  input logic [INDEX_W-1:0] smp_sample_index,
  input logic [CHAN_W-1:0]  smp_out_red,
  input logic [CHAN_W-1:0]  smp_out_green,
  input logic [CHAN_W-1:0]  smp_out_blue,
  input logic [CHAN_W-1:0]  smp_step_delay,
  input logic [CHAN_W-1:0]  smp_loop_pause,
  input logic               smp_last
);

  localparam logic [INDEX_W-1:0] LAST_IDX = INDEX_W'(PATTERN_SAMPLES - 1);
  localparam int PAYLOAD_W = INDEX_W + 5 * CHAN_W + 1;

  logic [PAYLOAD_W-1:0] payload;

  assign payload = {smp_sample_index, smp_out_red, smp_out_green, smp_out_blue,
                    smp_step_delay, smp_loop_pause, smp_last};

  // A stalled beat holds.
  `LKPB_ASSERT_NXT(a_stall_hold, smp_valid && !smp_ready, smp_valid && $stable(payload))

  // The end-of-run mark sits on the final position only.
  `LKPB_ASSERT_IMP(a_last_pos, smp_valid && smp_last, smp_sample_index == LAST_IDX)

  // Within a run, positions advance by one from beat to beat.
  `LKPB_ASSERT_NXT(a_index_step, smp_valid && smp_ready && !smp_last, !smp_valid || (smp_sample_index == $past(smp_sample_index) + INDEX_W'(1)))

  // A new run starts at position zero.
  `LKPB_ASSERT_NXT(a_run_start, smp_valid && smp_ready && smp_last, !smp_valid || (smp_sample_index == '0))

endmodule

bind led_keyframe_pattern_builder lkpb_checker #(
  .PATTERN_SAMPLES (PATTERN_SAMPLES)
) u_lkpb_checker (
  .clk              (clk),
  .rst              (rst),
  .smp_valid        (smp.valid),
  .smp_ready        (smp.ready),
  .smp_sample_index (smp.sample_index),
  .smp_out_red      (smp.out_red),
  .smp_out_green    (smp.out_green),
  .smp_out_blue     (smp.out_blue),
  .smp_step_delay   (smp.step_delay),
  .smp_loop_pause   (smp.loop_pause),
  .smp_last         (smp.last)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import lkpb_pkg::*;

  localparam int SLOTS             = PATTERN_SAMPLES_DEF;
  // A play run scans every slot and divides once per keyframe; allow the
  // densest table plus some margin before touching the register port.
  localparam int RUN_SETTLE_CYCLES = 2 * SLOTS + 11 * SLOTS + 64;
  localparam int IDLE_PERCENT      = 37;
  localparam int RANDOM_PHASES     = 8;
  localparam int PHASE_ITEMS       = 60;
  localparam int HOLDOFF_CYCLES    = 400;

  // Function codes past stop, and register indexes past loop_pause_time.
  localparam logic [FUNC_W-1:0]    FUNC_FIRST_UNUSED = FUNC_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED  = CFG_IDX_W'(2);
  localparam logic [TIME_W-1:0]    TIME_MAX          = '1;
  localparam logic [TIME_W-1:0]    TIME_SAT_EDGE     = TIME_W'(1 << CHAN_W);

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  step_delay;
    logic [CHAN_W-1:0]  loop_pause;
    logic               last;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lkpb_cmd_if cmd_bus ();
  lkpb_smp_if smp_bus ();
  lkpb_cfg_if cfg_bus ();

  led_keyframe_pattern_builder dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .smp (smp_bus),
    .cfg (cfg_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the keyframe table, the play flag and both timing registers.
  bit                  keyframe_valid  [SLOTS];
  logic [COLOUR_W-1:0] keyframe_colour [SLOTS];
  bit                  keyframe_hold   [SLOTS];
  bit                  pattern_playing;
  logic [TIME_W-1:0]   step_time_reg;
  logic [TIME_W-1:0]   loop_pause_reg;

  // Colour of every sample for the next play run.
  logic [COLOUR_W-1:0] pattern_colour [SLOTS];

  // Samples still owed by the block, oldest first.
  sample_t expected_samples[$];

  int error_count     = 0;
  bit tx_steady       = 1'b0;
  bit rx_steady       = 1'b0;
  int rx_holdoff_left = 0;

  function automatic logic [CHAN_W-1:0] saturate_time(input logic [TIME_W-1:0] t);
    return (t >= TIME_SAT_EDGE) ? '1 : t[CHAN_W-1:0];
  endfunction

  // Wipe the table; after reset slot 0 stays as a black keyframe.
  function automatic void reset_keyframes(input bit keep_origin);
    for (int s = 0; s < SLOTS; s++) begin
      keyframe_valid[s]  = 1'b0;
      keyframe_colour[s] = '0;
      keyframe_hold[s]   = 1'b0;
    end
    keyframe_valid[0] = keep_origin;
  endfunction

  // Interpolate between neighbouring keyframes. Each channel steps by the
  // difference over the span, truncated toward zero, unless the next
  // keyframe is a hold, in which case the colour stays flat into it.
  function automatic void render_pattern();
    int nxt;
    int span;
    int lo;
    int hi;
    int stride;
    int level;
    for (int i = 0; i < SLOTS; i++)
      pattern_colour[i] = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (!keyframe_valid[s])
        continue;
      nxt = s + 1;
      while (nxt < SLOTS && !keyframe_valid[nxt])
        nxt++;
      if (nxt >= SLOTS) begin
        // Last keyframe: hold to the end, no division.
        for (int i = s; i < SLOTS; i++)
          pattern_colour[i] = keyframe_colour[s];
        break;
      end
      span = nxt - s;
      for (int i = s; i < nxt; i++) begin
        for (int c = 0; c < NUM_CHAN; c++) begin
          lo     = keyframe_colour[s][c*CHAN_W +: CHAN_W];
          hi     = keyframe_colour[nxt][c*CHAN_W +: CHAN_W];
          stride = (hi - lo) / span;
          level  = keyframe_hold[nxt] ? lo : lo + stride * (i - s);
          pattern_colour[i][c*CHAN_W +: CHAN_W] = level[CHAN_W-1:0];
        end
      end
      pattern_colour[nxt] = keyframe_colour[nxt];
    end
  endfunction

  // Queue one full run; a blanking run carries zero colours and delays.
  function automatic void queue_run(input bit blank);
    sample_t s;
    for (int i = 0; i < SLOTS; i++) begin
      s.index      = INDEX_W'(i);
      {s.red, s.green, s.blue} = blank ? '0 : pattern_colour[i];
      s.step_delay = blank ? '0 : saturate_time(step_time_reg);
      s.loop_pause = blank ? '0 : saturate_time(loop_pause_reg);
      s.last       = (i == SLOTS - 1);
      expected_samples.push_back(s);
    end
  endfunction

  function automatic void apply_command(input logic [FUNC_W-1:0] func,
                                        input logic [SAMPLE_W-1:0] slot,
                                        input logic [COLOUR_W-1:0] colour,
                                        input logic hold);
    case (func)
      OP_ADD: begin
        if (slot < SLOTS) begin
          keyframe_valid[slot]  = 1'b1;
          keyframe_colour[slot] = colour;
          keyframe_hold[slot]   = hold;
        end
      end
      OP_DEL: begin
        if (slot < SLOTS) begin
          keyframe_valid[slot]  = 1'b0;
          keyframe_colour[slot] = '0;
          keyframe_hold[slot]   = 1'b0;
        end
      end
      OP_CLR: reset_keyframes(1'b0);
      OP_PLAY: begin
        render_pattern();
        queue_run(1'b0);
        pattern_playing = 1'b1;
      end
      OP_STOP: begin
        // Stop only answers while a pattern is playing.
        if (pattern_playing) begin
          queue_run(1'b1);
          pattern_playing = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got_v,
                                 input int unsigned want_v);
    $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got_v, want_v);
    error_count++;
  endtask

  task automatic check_field(input string what, input int unsigned got_v,
                             input int unsigned want_v);
    if (got_v !== want_v)
      report_mismatch(what, got_v, want_v);
  endtask

  // Offer one command beat. Valid stays high after acceptance; the next command
  // replaces or drops it, or the settle task drops it, on the following falling edge.
  task automatic send_command(input logic [FUNC_W-1:0] func,
                              input logic [SAMPLE_W-1:0] slot,
                              input logic [CHAN_W-1:0] red,
                              input logic [CHAN_W-1:0] green,
                              input logic [CHAN_W-1:0] blue,
                              input logic hold);
    int gap;
    gap = (!tx_steady && $urandom_range(99) < IDLE_PERCENT) ? $urandom_range(3, 1) : 0;
    @(negedge clk);
    repeat (gap) begin
      cmd_bus.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_bus.valid  <= 1'b1;
    cmd_bus.func   <= func;
    cmd_bus.sample <= slot;
    cmd_bus.red    <= red;
    cmd_bus.green  <= green;
    cmd_bus.blue   <= blue;
    cmd_bus.hold   <= hold;
    do @(posedge clk); while (!cmd_bus.ready);
    apply_command(func, slot, {red, green, blue}, hold);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [TIME_W-1:0] data);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    if (index == REG_STEP_TIME)
      step_time_reg = data;
    else if (index == REG_LOOP_PAUSE)
      loop_pause_reg = data;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Drop the command valid, drain every owed sample, then give the engine
  // time to finish commands that produce no beats.
  task automatic settle();
    @(negedge clk);
    cmd_bus.valid <= 1'b0;
    while (expected_samples.size() != 0)
      @(posedge clk);
    repeat (RUN_SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CHAN_W-1:0] pick_level();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return CHAN_W'($urandom_range(255));
    endcase
  endfunction

  // Mostly keyframe edits and runs; the odd clear, stray slot or unused code.
  task automatic random_command();
    int unsigned         pick;
    logic [FUNC_W-1:0]   func;
    logic [SAMPLE_W-1:0] slot;
    pick = $urandom_range(99);
    if (pick < 50)
      func = OP_ADD;
    else if (pick < 62)
      func = OP_DEL;
    else if (pick < 64)
      func = OP_CLR;
    else if (pick < 80)
      func = OP_PLAY;
    else if (pick < 95)
      func = OP_STOP;
    else
      func = FUNC_W'(FUNC_FIRST_UNUSED + $urandom_range(2));
    slot = ($urandom_range(7) == 0) ? SAMPLE_W'($urandom_range(63))
                                    : SAMPLE_W'($urandom_range(SLOTS - 1));
    send_command(func, slot, pick_level(), pick_level(), pick_level(),
                 $urandom_range(2) == 0);
  endtask

  // Straight out of reset: black origin held to the end, zero delays; stop
  // answers once, then not at all; unused codes produce nothing.
  task automatic test_reset_state();
    send_command(OP_PLAY, '0, '0, '0, '0, 1'b0);
    send_command(OP_STOP, '0, '0, '0, '0, 1'b0);
    send_command(OP_STOP, '1, '1, '1, '1, 1'b1);
    for (int k = 0; k < 3; k++)
      send_command(FUNC_W'(FUNC_FIRST_UNUSED + k), '0, '1, '0, '1, 1'b1);
  endtask

  // Saturating delays on an empty table: colours all black, delays at 255.
  task automatic test_empty_table();
    settle();
    write_register(REG_STEP_TIME, TIME_MAX);
    write_register(REG_LOOP_PAUSE, TIME_SAT_EDGE);
    write_register(REG_FIRST_UNUSED, '0);
    send_command(OP_CLR, '0, '0, '0, '0, 1'b0);
    send_command(OP_PLAY, '0, '0, '0, '0, 1'b0);
  endtask

  // Rising and falling ramps, a hold into a keyframe, a keyframe in the
  // final slot, out-of-range slots, a replay while playing and deletions.
  task automatic test_keyframe_ramps();
    send_command(OP_ADD, SAMPLE_W'(3), 8'hFF, 8'h00, 8'hFF, 1'b0);
    send_command(OP_ADD, SAMPLE_W'(10), 8'h00, 8'hFF, 8'h01, 1'b0);
    send_command(OP_ADD, SAMPLE_W'(20), 8'hC8, 8'h64, 8'h32, 1'b1);
    send_command(OP_ADD, SAMPLE_W'(SLOTS - 1), 8'h11, 8'h22, 8'h33, 1'b0);
    send_command(OP_ADD, '1, '1, '1, '1, 1'b1);
    send_command(OP_ADD, SAMPLE_W'(SLOTS), 8'h80, 8'h80, 8'h80, 1'b0);
    send_command(OP_DEL, SAMPLE_W'(40), '0, '0, '0, 1'b0);
    send_command(OP_PLAY, '0, '0, '0, '0, 1'b0);
    send_command(OP_PLAY, '0, '0, '0, '0, 1'b0);
    send_command(OP_DEL, SAMPLE_W'(SLOTS - 1), '0, '0, '0, 1'b0);
    send_command(OP_DEL, SAMPLE_W'(3), '0, '0, '0, 1'b0);
    send_command(OP_PLAY, '0, '0, '0, '0, 1'b0);
    send_command(OP_STOP, '0, '0, '0, '0, 1'b0);
  endtask

  // Hold the sample side off for a long stretch while plays keep coming,
  // so the command queue fills and cmd ready drops.
  task automatic test_backpressure();
    settle();
    rx_holdoff_left = HOLDOFF_CYCLES;
    tx_steady = 1'b1;
    repeat (4)
      send_command(OP_PLAY, '0, '0, '0, '0, 1'b0);
    tx_steady = 1'b0;
  endtask

  // Random traffic in phases; registers change between phases, one phase
  // runs with no idling on either side.
  task automatic test_random_traffic();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          write_register(REG_STEP_TIME, '0);
          write_register(REG_LOOP_PAUSE, '0);
        end
        1: begin
          write_register(REG_STEP_TIME, TIME_MAX);
          write_register(REG_LOOP_PAUSE, TIME_MAX);
        end
        2: begin
          write_register(REG_STEP_TIME, TIME_SAT_EDGE - 1);
          write_register(REG_LOOP_PAUSE, TIME_SAT_EDGE);
        end
        default: begin
          write_register(REG_STEP_TIME, TIME_W'($urandom_range(TIME_MAX)));
          write_register(REG_LOOP_PAUSE, TIME_W'($urandom_range(511)));
        end
      endcase
      write_register(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, REG_FIRST_UNUSED)),
                     TIME_W'($urandom_range(TIME_MAX)));
      tx_steady = (phase == 3);
      rx_steady = (phase == 3);
      repeat (PHASE_ITEMS)
        random_command();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Sample side ready: random stalls, a steady stretch, or a counted hold-off.
  initial begin
    smp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_holdoff_left > 0) begin
        smp_bus.ready <= 1'b0;
        rx_holdoff_left--;
      end else if (rx_steady) begin
        smp_bus.ready <= 1'b1;
      end else begin
        smp_bus.ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Compare each accepted sample beat with the oldest one owed.
  always @(posedge clk) begin
    sample_t got;
    sample_t want;
    if (!rst && smp_bus.valid && smp_bus.ready) begin
      got = {smp_bus.sample_index, smp_bus.out_red, smp_bus.out_green, smp_bus.out_blue,
             smp_bus.step_delay, smp_bus.loop_pause, smp_bus.last};
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected sample beat, index", got.index, 0);
      end else begin
        want = expected_samples.pop_front();
        check_field("sample_index", got.index, want.index);
        check_field("out_red", got.red, want.red);
        check_field("out_green", got.green, want.green);
        check_field("out_blue", got.blue, want.blue);
        check_field("step_delay", got.step_delay, want.step_delay);
        check_field("loop_pause", got.loop_pause, want.loop_pause);
        check_field("last", got.last, want.last);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    cmd_bus.valid  = 1'b0;
    cmd_bus.func   = '0;
    cmd_bus.sample = '0;
    cmd_bus.red    = '0;
    cmd_bus.green  = '0;
    cmd_bus.blue   = '0;
    cmd_bus.hold   = 1'b0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = '0;
    cfg_bus.data   = '0;
    reset_keyframes(1'b1);
    pattern_playing = 1'b0;
    step_time_reg   = '0;
    loop_pause_reg  = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_empty_table();
    test_keyframe_ramps();
    test_backpressure();
    test_random_traffic();
    settle();

    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
